>>> sv/capacitive_rotation_angle_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Rotation decoder assertion macros
// Shared property shapes for the port checker; clock aclk, reset aresetn.
// ----------------------------------------------------------------------------
`ifndef CAPACITIVE_ROTATION_ANGLE_DECODER_CORE_MACROS_SVH
`define CAPACITIVE_ROTATION_ANGLE_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define CRAD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define CRAD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/crad_pkg.sv
// ----------------------------------------------------------------------------
// crad_pkg
// Types, pattern table and constants of the rotation angle decoder.
// ----------------------------------------------------------------------------
package crad_pkg;

    localparam int CRAD_TABLE_ENTRIES = 12;
    localparam int CRAD_SCALE         = 1200;  // estimate scale, twentieths
    localparam int CRAD_STEP_ANGLE    = 600;   // 30 degrees in twentieths
    localparam int CRAD_SPREAD_DIV    = 10;
    localparam int CRAD_BATCH_RESET   = 100;

    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_QTR  = 2'd1;
    localparam logic [1:0] CODE_HALF = 2'd2;
    localparam logic [1:0] CODE_ZERO = 2'd3;

    typedef struct packed {
        logic [7:0]        simple_code;
        logic [3:0]        steps;
        logic [7:0]        complex_code;
        logic [1:0]        pad_a;
        logic signed [4:0] k_a;
        logic [1:0]        pad_b;
        logic signed [4:0] k_b;
    } crad_entry_t;

    typedef struct packed {
        logic              hit;
        logic              simple;
        logic [3:0]        steps;
        logic [1:0]        pad_a;
        logic signed [4:0] k_a;
        logic [1:0]        pad_b;
        logic signed [4:0] k_b;
    } crad_hit_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } crad_find_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SUM,
        ST_SEARCH,
        ST_TERM,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BATCH,
        ST_EMIT
    } crad_state_t;

    typedef enum logic [2:0] {
        OP_E1,
        OP_E2,
        OP_ANGLE,
        OP_SPREAD,
        OP_MARGIN
    } crad_op_t;

    localparam crad_entry_t CRAD_TABLE [CRAD_TABLE_ENTRIES] = '{
        '{8'b10_01_01_11, 4'd0,  8'b00_01_00_11, 2'd2, -5'sd1, 2'd0, 5'sd2},
        '{8'b01_01_10_11, 4'd1,  8'b00_00_10_11, 2'd1, 5'sd0,  2'd0, 5'sd2},
        '{8'b11_10_10_11, 4'd2,  8'b11_10_00_00, 2'd3, 5'sd2,  2'd2, 5'sd4},
        '{8'b11_10_01_01, 4'd3,  8'b11_00_01_00, 2'd3, 5'sd2,  2'd1, 5'sd5},
        '{8'b11_01_01_10, 4'd4,  8'b11_00_00_10, 2'd2, 5'sd3,  2'd1, 5'sd5},
        '{8'b11_11_10_10, 4'd5,  8'b00_11_10_00, 2'd0, 5'sd5,  2'd3, 5'sd7},
        '{8'b01_11_10_01, 4'd6,  8'b00_11_00_01, 2'd0, 5'sd5,  2'd2, 5'sd8},
        '{8'b10_11_01_01, 4'd7,  8'b10_11_00_00, 2'd3, 5'sd6,  2'd2, 5'sd8},
        '{8'b10_11_11_10, 4'd8,  8'b00_00_11_10, 2'd1, 5'sd8,  2'd0, 5'sd10},
        '{8'b01_01_11_10, 4'd9,  8'b01_00_11_00, 2'd1, 5'sd8,  2'd3, 5'sd11},
        '{8'b01_10_11_01, 4'd10, 8'b00_10_11_00, 2'd0, 5'sd9,  2'd3, 5'sd11},
        '{8'b10_10_11_11, 4'd11, 8'b10_00_00_11, 2'd2, 5'sd11, 2'd1, 5'sd13}
    };

    // First entry whose simple pattern equals the code.
    function automatic crad_find_t find_simple(input logic [7:0] code);
        crad_find_t f;
        f = '0;
        for (int i = CRAD_TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (CRAD_TABLE[i].simple_code == code) begin
                f.hit = 1'b1;
                f.idx = 4'(i);
            end
        end
        return f;
    endfunction

    // First entry whose two-unknown pattern equals the code.
    function automatic crad_find_t find_complex(input logic [7:0] code);
        crad_find_t f;
        f = '0;
        for (int i = CRAD_TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (CRAD_TABLE[i].complex_code == code) begin
                f.hit = 1'b1;
                f.idx = 4'(i);
            end
        end
        return f;
    endfunction

endpackage

>>> sv/capacitive_rotation_angle_decoder_core.sv
// ----------------------------------------------------------------------------
// capacitive_rotation_angle_decoder_core: four-pad rotation angle decoder
// Per reading: normalise, sum, then a margin search; a match with unknown pads
// runs the shared divider twice for its two estimates; the end of a batch with
// hits runs it three more times for the averages. Readings are taken one at a time.
// Reset (aresetn low, synchronous): sums clear, batch_length returns to 100.
// ----------------------------------------------------------------------------
module capacitive_rotation_angle_decoder_core import crad_pkg::*; #(
    parameter int LEVEL_WIDTH = 10
) (
    input  logic aclk,
    input  logic aresetn,
    // batch length register
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,
    // reading request: pad0_level, pad1_level, pad2_level, pad3_level
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((4*LEVEL_WIDTH+7)/8)*8-1:0]  s_tdata,
    // result request: angle_tenths, hit_total, mean_spread, mean_margin, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // batch_valid
    output logic [0:0]  m_tuser
);

    localparam int LW    = LEVEL_WIDTH;
    localparam int TW    = LW + 5;           // signed pad term
    localparam int NW    = LW + 16;          // signed scaled numerator
    localparam int DIV_D = 32;
    localparam int DIV_W = (LW + 2 > 12) ? LW + 2 : 12;

    // sequencer and reading state
    crad_state_t   state_reg, state_next;
    crad_op_t      op_reg, op_next;
    logic [LW-1:0] raw_reg [4];
    logic [LW-1:0] raw_next [4];
    logic [LW-1:0] lv_reg [4];
    logic [LW-1:0] lv_next [4];
    logic [LW+1:0] total_reg, total_next;
    logic [LW-1:0] m_reg, m_next;
    crad_hit_t     ent_reg, ent_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic signed [31:0]   e1_reg, e1_next;

    // batch accumulators and register
    logic [31:0] angle_sum_reg, angle_sum_next;
    logic [15:0] spread_sum_reg, spread_sum_next;
    logic [15:0] margin_sum_reg, margin_sum_next;
    logic [7:0]  hit_count_reg, hit_count_next;
    logic [7:0]  batch_index_reg, batch_index_next;
    logic [7:0]  batch_len_reg;

    // result fields and output stage
    logic [15:0] res_angle_reg, res_angle_next;
    logic [7:0]  res_hit_reg, res_hit_next;
    logic [12:0] res_spread_reg, res_spread_next;
    logic [9:0]  res_margin_reg, res_margin_next;
    logic        res_valid_reg, res_valid_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic [0:0]  m_tuser_reg, m_tuser_next;

    // combinational helpers
    logic [LW-1:0]        quarter;
    logic [LW:0]          half;
    logic [LW-1:0]        mn;
    logic [LW+1:0]        sum_w;
    crad_hit_t            hit;
    logic signed [TW-1:0] q_s;
    logic signed [TW-1:0] term_a, term_b;
    logic [NW-1:0]        num_mag;
    logic signed [31:0]   q_signed;
    logic signed [32:0]   e_diff;
    logic [32:0]          e_abs;
    logic [7:0]           idx_inc;
    logic                 div_start;
    logic [DIV_D-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_D-1:0]     div_quot;

    assign half    = total_reg[LW+1:1];
    assign quarter = total_reg[LW+1:2];

    // pad coding and table lookup at the current margin
    crad_match #(.LEVEL_WIDTH(LW)) u_match (
        .lv      (lv_reg),
        .quarter (quarter),
        .half    (half),
        .margin  (m_reg),
        .result  (hit)
    );

    // one divider serves the estimates and the batch averages
    crad_div #(.DW(DIV_D), .VW(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        raw_next         = raw_reg;
        lv_next          = lv_reg;
        total_next       = total_reg;
        m_next           = m_reg;
        ent_next         = ent_reg;
        t_next           = t_reg;
        num_next         = num_reg;
        e1_next          = e1_reg;
        angle_sum_next   = angle_sum_reg;
        spread_sum_next  = spread_sum_reg;
        margin_sum_next  = margin_sum_reg;
        hit_count_next   = hit_count_reg;
        batch_index_next = batch_index_reg;
        res_angle_next   = res_angle_reg;
        res_hit_next     = res_hit_reg;
        res_spread_next  = res_spread_reg;
        res_margin_next  = res_margin_reg;
        res_valid_next   = res_valid_reg;
        // drop the held result once the sink takes it
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;

        // minimum of the raw pads
        mn = raw_reg[0];
        for (int p = 1; p < 4; p++) begin
            if (raw_reg[p] < mn) begin
                mn = raw_reg[p];
            end
        end
        sum_w = '0;
        for (int p = 0; p < 4; p++) begin
            sum_w = sum_w + (LW + 2)'(lv_reg[p]);
        end

        // pad terms of the two estimates
        q_s    = $signed({5'b0, quarter});
        term_a = $signed({5'b0, lv_reg[ent_reg.pad_a]}) + TW'(ent_reg.k_a) * q_s;
        term_b = TW'(ent_reg.k_b) * q_s - $signed({5'b0, lv_reg[ent_reg.pad_b]});

        // divide magnitudes, then restore the sign (truncates toward zero)
        num_mag  = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
        q_signed = num_reg[NW-1] ? -$signed(div_quot) : $signed(div_quot);
        e_diff   = 33'(e1_reg) - 33'(q_signed);
        e_abs    = e_diff[32] ? 33'(-e_diff) : 33'(e_diff);
        idx_inc  = batch_index_reg + 8'd1;

        case (state_reg)
            ST_IDLE: begin
                // latch the reading request
                if (s_tvalid) begin
                    for (int p = 0; p < 4; p++) begin
                        raw_next[p] = s_tdata[p*LW +: LW];
                    end
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                for (int p = 0; p < 4; p++) begin
                    lv_next[p] = raw_reg[p] - mn;
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                total_next = sum_w;
                m_next     = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                // widen the margin one step a cycle until a match or the limit
                if (m_reg >= quarter) begin
                    state_next = ST_BATCH;
                end else if (hit.hit) begin
                    margin_sum_next = margin_sum_reg + 16'(m_reg);
                    hit_count_next  = hit_count_reg + 8'd1;
                    if (hit.simple) begin
                        angle_sum_next = angle_sum_reg
                                       + 32'(hit.steps) * 32'(CRAD_STEP_ANGLE);
                        state_next     = ST_BATCH;
                    end else begin
                        ent_next   = hit;
                        op_next    = OP_E1;
                        state_next = ST_TERM;
                    end
                end else begin
                    m_next = m_reg + LW'(1);
                end
            end
            ST_TERM: begin
                t_next     = (op_reg == OP_E1) ? term_a : term_b;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                num_next   = NW'(t_reg) * NW'(CRAD_SCALE);
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
                case (op_reg)
                    OP_E1, OP_E2: begin
                        div_dividend = DIV_D'(num_mag);
                        div_divisor  = DIV_W'(total_reg);
                    end
                    OP_ANGLE: begin
                        // (sum / hits) / 2 equals sum / (2 * hits)
                        div_dividend = angle_sum_reg;
                        div_divisor  = DIV_W'({hit_count_reg, 1'b0});
                    end
                    OP_SPREAD: begin
                        div_dividend = DIV_D'(spread_sum_reg);
                        div_divisor  = DIV_W'(hit_count_reg) * DIV_W'(CRAD_SPREAD_DIV);
                    end
                    OP_MARGIN: begin
                        div_dividend = DIV_D'(margin_sum_reg);
                        div_divisor  = DIV_W'(hit_count_reg);
                    end
                    default: begin
                        div_start = 1'b0;
                    end
                endcase
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (op_reg)
                        OP_E1: begin
                            e1_next    = q_signed;
                            op_next    = OP_E2;
                            state_next = ST_TERM;
                        end
                        OP_E2: begin
                            angle_sum_next  = angle_sum_reg + 32'(e1_reg + q_signed);
                            spread_sum_next = spread_sum_reg + e_abs[15:0];
                            state_next      = ST_BATCH;
                        end
                        OP_ANGLE: begin
                            res_angle_next = div_quot[15:0];
                            op_next        = OP_SPREAD;
                            state_next     = ST_DIV_START;
                        end
                        OP_SPREAD: begin
                            res_spread_next = div_quot[12:0];
                            op_next         = OP_MARGIN;
                            state_next      = ST_DIV_START;
                        end
                        OP_MARGIN: begin
                            res_margin_next = div_quot[9:0];
                            state_next      = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BATCH: begin
                // close the batch once the count reaches the length
                if (idx_inc < batch_len_reg) begin
                    batch_index_next = idx_inc;
                    state_next       = ST_IDLE;
                end else if (hit_count_reg == 8'd0) begin
                    res_angle_next  = '0;
                    res_hit_next    = '0;
                    res_spread_next = '0;
                    res_margin_next = '0;
                    res_valid_next  = 1'b0;
                    state_next      = ST_EMIT;
                end else begin
                    res_hit_next   = hit_count_reg;
                    res_valid_next = 1'b1;
                    op_next        = OP_ANGLE;
                    state_next     = ST_DIV_START;
                end
            end
            ST_EMIT: begin
                // hold until the output stage is free, then restart the sums
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = {1'b0, res_margin_reg, res_spread_reg,
                                        res_hit_reg, res_angle_reg};
                    m_tuser_next     = res_valid_reg;
                    angle_sum_next   = '0;
                    spread_sum_next  = '0;
                    margin_sum_next  = '0;
                    hit_count_next   = '0;
                    batch_index_next = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            angle_sum_reg   <= '0;
            spread_sum_reg  <= '0;
            margin_sum_reg  <= '0;
            hit_count_reg   <= '0;
            batch_index_reg <= '0;
            batch_len_reg   <= 8'(CRAD_BATCH_RESET);
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            angle_sum_reg   <= angle_sum_next;
            spread_sum_reg  <= spread_sum_next;
            margin_sum_reg  <= margin_sum_next;
            hit_count_reg   <= hit_count_next;
            batch_index_reg <= batch_index_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wen) begin
                batch_len_reg <= cfg_wdata;
            end
        end
        op_reg         <= op_next;
        raw_reg        <= raw_next;
        lv_reg         <= lv_next;
        total_reg      <= total_next;
        m_reg          <= m_next;
        ent_reg        <= ent_next;
        t_reg          <= t_next;
        num_reg        <= num_next;
        e1_reg         <= e1_next;
        res_angle_reg  <= res_angle_next;
        res_hit_reg    <= res_hit_next;
        res_spread_reg <= res_spread_next;
        res_margin_reg <= res_margin_next;
        res_valid_reg  <= res_valid_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sv/crad_div.sv
// ----------------------------------------------------------------------------
// crad_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module crad_div #(
    parameter int DW = 32,
    parameter int VW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic [VW+1:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = {1'b0, shifted} - {2'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the shifted remainder unless the subtraction fits
            if (!trial[VW+1]) begin
                rem_next = trial[VW-1:0];
            end else begin
                rem_next = shifted[VW-1:0];
            end
            quo_next = {quo_reg[DW-2:0], ~trial[VW+1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/crad_match.sv
// ----------------------------------------------------------------------------
// crad_match
// Codes the four pads at one margin and looks the code up in the table.
// ----------------------------------------------------------------------------
module crad_match import crad_pkg::*; #(
    parameter int LEVEL_WIDTH = 10
) (
    input  logic [LEVEL_WIDTH-1:0] lv [4],
    input  logic [LEVEL_WIDTH-1:0] quarter,
    input  logic [LEVEL_WIDTH:0]   half,
    input  logic [LEVEL_WIDTH-1:0] margin,
    output crad_hit_t              result
);

    localparam int LW = LEVEL_WIDTH;

    logic [7:0]    code;
    logic [2:0]    nones;
    logic [LW-1:0] dq;
    logic [LW:0]   dh;
    logic [LW:0]   lv_w;
    logic [1:0]    pc;
    crad_find_t    fs, fc, fsel;
    logic [7:0]    cand;

    always_comb begin
        code  = '0;
        nones = '0;
        dq    = '0;
        dh    = '0;
        lv_w  = '0;
        pc    = CODE_NONE;
        for (int p = 0; p < 4; p++) begin
            lv_w = {1'b0, lv[p]};
            dq   = (lv[p] >= quarter) ? lv[p] - quarter : quarter - lv[p];
            dh   = (lv_w >= half) ? lv_w - half : half - lv_w;
            if (lv[p] < margin) begin
                pc = CODE_ZERO;
            end else if (dq < margin) begin
                pc = CODE_QTR;
            end else if (dh < {1'b0, margin}) begin
                pc = CODE_HALF;
            end else begin
                pc = CODE_NONE;
            end
            if (pc == CODE_NONE) begin
                nones = nones + 3'd1;
            end
            code[7-2*p -: 2] = pc;
        end

        fs = find_simple(code);
        fc = find_complex(code);

        // one unknown: clear pad 0, then 1, 2, 3; the last hit wins
        fsel = '0;
        cand = '0;
        for (int p = 3; p >= 0; p--) begin
            cand = code & ~(8'd3 << (2 * p));
            if (find_complex(cand).hit) begin
                fsel = find_complex(cand);
            end
        end

        result = '0;
        case (nones)
            3'd0: begin
                result.hit    = fs.hit;
                result.simple = 1'b1;
                fsel          = fs;
            end
            3'd1: begin
                result.hit = fsel.hit;
            end
            3'd2: begin
                result.hit = fc.hit;
                fsel       = fc;
            end
            default: begin
                result.hit = 1'b0;
            end
        endcase
        result.steps = CRAD_TABLE[fsel.idx].steps;
        result.pad_a = CRAD_TABLE[fsel.idx].pad_a;
        result.k_a   = CRAD_TABLE[fsel.idx].k_a;
        result.pad_b = CRAD_TABLE[fsel.idx].pad_b;
        result.k_b   = CRAD_TABLE[fsel.idx].k_b;
    end

endmodule

>>> sv/crad_checker.sv
// ----------------------------------------------------------------------------
// crad_checker
// Port-level checks of the rotation decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "capacitive_rotation_angle_decoder_core_macros.svh"

module crad_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result holds
    `CRAD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // a reading keeps the block busy in the next cycle
    `CRAD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after a reading")
    // an empty batch reports all fields zero
    `CRAD_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == 48'd0, "empty batch with data")
    // a valid batch has at least one hit
    `CRAD_ASSERT_NOW(a_valid_hits, m_tvalid && m_tuser[0], m_tdata[23:16] != 8'd0, "valid batch without hits")

endmodule

bind capacitive_rotation_angle_decoder_core crad_checker u_crad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/tb_capacitive_rotation_angle_decoder_core.sv
// ----------------------------------------------------------------------------
// Rotation angle decoder core testbench
// Feeds four-pad readings (directed corners, well-formed pad patterns with
// random content, and raw noise) through the request stream under random
// bursts and back-pressure. A local model of the margin search and batch
// averaging predicts each batch result. The batch length is reprogrammed
// between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_capacitive_rotation_angle_decoder_core;
    import crad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LW        = 10;
    localparam int SETTLE    = 1500;   // worst reading plus end-of-batch divides
    localparam int IDLE_MAX  = 40000;  // cycles with no request moving
    localparam int HOLD_LONG = 4000;

    typedef struct {
        logic [15:0] angle;
        logic [7:0]  hits;
        logic [12:0] spread;
        logic [9:0]  margin;
        logic        valid;
    } batch_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // pad0, pad1, pad2, pad3 (10 bits each)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // angle 16, hits 8, spread 13, margin 10, pad 1
    logic [0:0]  m_tuser;        // batch_valid

    capacitive_rotation_angle_decoder_core #(.LEVEL_WIDTH(LW)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model state
    logic [31:0] angle_acc;
    logic [15:0] spread_acc, margin_acc;
    logic [7:0]  hit_acc, reading_idx, batch_len;

    logic [39:0] reading_q[$];
    batch_res_t  batch_q[$];
    int errors = 0, readings_done = 0, batches_seen = 0, idle_cycles = 0;
    bit hold_go = 0;

    function automatic longint absdiff(longint a, longint b);
        return a < b ? b - a : a - b;
    endfunction

    // Try a two-unknown code; update sums on a hit.
    function automatic bit try_estimate(logic [7:0] code, longint lv[4], longint total,
                                        longint qtr);
        longint e1, e2;
        for (int i = 0; i < CRAD_TABLE_ENTRIES; i++) begin
            if (CRAD_TABLE[i].complex_code == code) begin
                e1 = (lv[CRAD_TABLE[i].pad_a] + longint'(CRAD_TABLE[i].k_a) * qtr) * 1200
                     / total;
                e2 = (longint'(CRAD_TABLE[i].k_b) * qtr - lv[CRAD_TABLE[i].pad_b]) * 1200
                     / total;
                angle_acc  = angle_acc + 32'(e1 + e2);
                spread_acc = spread_acc + 16'(absdiff(e1, e2));
                return 1;
            end
        end
        return 0;
    endfunction

    // Decode one reading and advance the batch; queue a result at batch end.
    function automatic void predict_reading(logic [39:0] d);
        longint lv[4];
        longint lo, total, half, qtr;
        logic [7:0] code;
        int nones;
        bit found;
        batch_res_t r;
        for (int p = 0; p < 4; p++) lv[p] = d[p*LW +: LW];
        lo = lv[0];
        for (int p = 1; p < 4; p++) if (lv[p] < lo) lo = lv[p];
        total = 0;
        for (int p = 0; p < 4; p++) begin
            lv[p] -= lo;
            total += lv[p];
        end
        half = total >> 1;
        qtr = half >> 1;
        found = 0;
        for (longint m = 0; !found && m < (total >> 2); m++) begin
            code = '0;
            nones = 0;
            for (int p = 0; p < 4; p++) begin
                code = code << 2;
                if (lv[p] < m) code[1:0] = CODE_ZERO;
                else if (absdiff(lv[p], qtr) < m) code[1:0] = CODE_QTR;
                else if (absdiff(lv[p], half) < m) code[1:0] = CODE_HALF;
                else nones++;
            end
            if (nones == 0) begin
                for (int i = 0; i < CRAD_TABLE_ENTRIES && !found; i++)
                    if (CRAD_TABLE[i].simple_code == code) begin
                        angle_acc = angle_acc + 32'(CRAD_TABLE[i].steps) * 600;
                        found = 1;
                    end
            end else if (nones == 1) begin
                // patch: drop one known pad at a time, pad 3 first
                for (int p = 0; p < 4 && !found; p++)
                    found = try_estimate(code & ~(8'd3 << (2 * p)), lv, total, qtr);
            end else if (nones == 2) begin
                found = try_estimate(code, lv, total, qtr);
            end
            if (found) begin
                margin_acc = margin_acc + 16'(m);
                hit_acc = hit_acc + 8'd1;
            end
        end
        reading_idx = reading_idx + 8'd1;
        if (reading_idx < batch_len) return;
        r = '{default: '0};
        if (hit_acc != 0) begin
            r.angle  = 16'(angle_acc / hit_acc / 2);
            r.hits   = hit_acc;
            r.spread = 13'(32'(spread_acc) / hit_acc / 10);
            r.margin = 10'(32'(margin_acc) / hit_acc);
            r.valid  = 1'b1;
        end
        batch_q.push_back(r);
        angle_acc = 0; spread_acc = 0; margin_acc = 0; hit_acc = 0; reading_idx = 0;
    endfunction

    // Build a reading that fits a table pattern, with random base and scale.
    function automatic logic [39:0] pattern_reading(bit use_simple);
        int e, base, q;
        logic [7:0] code;
        logic [1:0] c;
        logic [39:0] d;
        int v;
        e = $urandom_range(0, CRAD_TABLE_ENTRIES - 1);
        code = use_simple ? CRAD_TABLE[e].simple_code : CRAD_TABLE[e].complex_code;
        base = $urandom_range(0, 200);
        q = $urandom_range(1, 150);
        for (int p = 0; p < 4; p++) begin
            c = code[7 - 2*p -: 2];
            case (c)
                CODE_ZERO: v = base;
                CODE_QTR:  v = base + q;
                CODE_HALF: v = base + 2*q;
                default:   v = base + $urandom_range(0, 4*q);
            endcase
            v += $urandom_range(0, 2);
            d[p*LW +: LW] = LW'(v);
        end
        return d;
    endfunction

    function automatic void queue_random(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: reading_q.push_back(pattern_reading(1));
                4, 5, 6:    reading_q.push_back(pattern_reading(0));
                default:    reading_q.push_back(40'($urandom) | (40'($urandom) << 32));
            endcase
        end
    endfunction

    // Driver: bursts of requests with random gaps; predict on acceptance.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reading(s_tdata);
                readings_done++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (reading_q.size() != 0) begin
                    s_tdata  <= reading_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    int hold_left = 0;
    bit hold_used = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used <= 1;
            hold_left <= HOLD_LONG;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch batch %0d %s: got %0d expected %0d", batches_seen, what, got, want);
        errors++;
    endtask

    // Monitor: compare each result against the oldest expectation.
    always @(posedge aclk) begin
        batch_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (batch_q.size() == 0) begin
                $display("unexpected result at batch %0d", batches_seen);
                errors++;
            end else begin
                w = batch_q.pop_front();
                if (m_tdata[15:0] !== w.angle)   report_mismatch("angle", m_tdata[15:0], w.angle);
                if (m_tdata[23:16] !== w.hits)   report_mismatch("hits", m_tdata[23:16], w.hits);
                if (m_tdata[36:24] !== w.spread)
                    report_mismatch("spread", m_tdata[36:24], w.spread);
                if (m_tdata[46:37] !== w.margin)
                    report_mismatch("margin", m_tdata[46:37], w.margin);
                if (m_tuser[0] !== w.valid)      report_mismatch("valid", m_tuser[0], w.valid);
            end
            batches_seen++;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sample at the falling edge so the driver's updates have settled.
    task automatic drain();
        while (reading_q.size() != 0 || s_tvalid || batch_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_batch_len(logic [7:0] v);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        batch_len = v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        angle_acc = 0; spread_acc = 0; margin_acc = 0;
        hit_acc = 0; reading_idx = 0; batch_len = 8'd100;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners under the reset batch length.
        reading_q.push_back('0);                                     // all equal
        reading_q.push_back({4{10'h3FF}});                           // all full scale
        reading_q.push_back({10'd0, 10'd1, 10'd2, 10'd0});           // total below four
        reading_q.push_back({10'd0, 10'd0, 10'd0, 10'h3FF});         // one pad at top
        reading_q.push_back({10'h3FF, 10'h3FF, 10'h3FF, 10'd0});
        reading_q.push_back({10'h155, 10'h2AA, 10'h155, 10'h2AA});   // alternating bits
        for (int e = 0; e < CRAD_TABLE_ENTRIES; e++) begin
            // exact simple pattern, quarter step 100, on base 5
            logic [39:0] d;
            for (int p = 0; p < 4; p++) begin
                logic [1:0] c;
                c = CRAD_TABLE[e].simple_code[7 - 2*p -: 2];
                d[p*LW +: LW] = (c == CODE_ZERO) ? 10'd5 : (c == CODE_QTR) ? 10'd105 : 10'd205;
            end
            reading_q.push_back(d);
        end
        for (int i = 0; i < 6; i++) reading_q.push_back(pattern_reading(0));
        queue_random(76);                      // completes the first batch of 100
        drain();

        // Shortest batches; one long receiver hold fills the block.
        write_batch_len(8'd1);
        hold_go = 1;
        queue_random(20);
        drain();

        write_batch_len(8'd0);                 // behaves as one
        queue_random(6);
        drain();

        write_batch_len(8'd3);
        queue_random(10);                      // leaves a partial batch open
        drain();
        write_batch_len(8'd1);                 // below count: ends at next reading
        queue_random(4);
        drain();

        write_batch_len(8'd255);
        queue_random(148);                     // long batch left open
        drain();
        write_batch_len(8'd1);                 // cut the long batch short
        queue_random(2);
        drain();

        $display("readings %0d, results %0d; batch lengths 100, 1, 0, 3 and a cut 255",
                 readings_done, batches_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
